/* hw/rtl/its_pkg.sv */
// Shared types and constants for the tagged interval statistics table.
// No dependencies; imported by every its_* module and the top level.
package its_pkg;

  localparam int ENTRIES    = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int TAG_BITS   = 32;
  localparam int TIME_BITS  = 48;
  localparam int CNT_BITS   = 32;
  localparam int TOTAL_BITS = 64;
  localparam int SLOT_W     = 6;

  localparam int IN_TDATA_W  = 88;   // 32 + 48 + 6, padded to bytes
  localparam int OUT_TDATA_W = 328;  // 327 bits of fields, padded to bytes

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_END   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_UNUSED    = 2'd3
  } sts_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_UPD  = 1'b1
  } fsm_e;

  // One entry of the statistics memory
  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [TIME_BITS-1:0]  start;
    logic [CNT_BITS-1:0]   count;
    logic [TOTAL_BITS-1:0] total;
    logic [TIME_BITS-1:0]  max0;
    logic [TIME_BITS-1:0]  max1;
    logic [TIME_BITS-1:0]  min0;
    logic [TIME_BITS-1:0]  min1;
  } stat_t;

  // Result of the parallel tag compare
  typedef struct packed {
    logic             beg_hit;    // begin found a live match or a free entry
    logic             beg_free;   // the chosen begin entry is free (allocate)
    logic [IDX_W-1:0] beg_slot;
    logic             end_hit;
    logic [IDX_W-1:0] end_slot;
  } lookup_t;

  // Update of the tag registers and live bits
  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    slot;
    logic [TAG_BITS-1:0] key;
    logic                clear_all;
  } cam_wr_t;

endpackage

/* hw/rtl/its_stat_ram.sv */
// Statistics memory: one write port, one registered read port.
// Depends on its_pkg for the entry layout and depth.
module its_stat_ram (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [its_pkg::IDX_W-1:0] rd_addr_i,
  output its_pkg::stat_t       rd_data_o,
  input  logic                 wr_en_i,
  input  logic [its_pkg::IDX_W-1:0] wr_addr_i,
  input  its_pkg::stat_t       wr_data_i
);
  import its_pkg::*;

  stat_t mem [ENTRIES];
  stat_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/its_tag_cam.sv */
// Tag registers with live bits and parallel key compare / priority pick.
// Depends on its_pkg for lookup_t and cam_wr_t.
module its_tag_cam (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [its_pkg::TAG_BITS-1:0] key_i,
  input  its_pkg::cam_wr_t          wr_i,
  output its_pkg::lookup_t          lookup_o,
  output logic [its_pkg::ENTRIES-1:0] used_o
);
  import its_pkg::*;

  logic [TAG_BITS-1:0] tag_q [ENTRIES];
  logic [ENTRIES-1:0]  used_q;
  logic [ENTRIES-1:0]  beg_vec;
  logic [ENTRIES-1:0]  end_vec;
  logic [ENTRIES-1:0]  eq_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.clear_all) begin
      used_q <= '0;
    end else if (wr_i.wr_en) begin
      used_q[wr_i.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      tag_q[wr_i.slot] <= wr_i.key;
    end
  end

  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      eq_vec[e]  = (tag_q[e] == key_i);
      beg_vec[e] = !used_q[e] || eq_vec[e];
      end_vec[e] = used_q[e] && eq_vec[e];
    end
  end

  // lowest index wins: scan downward so the last hit written is the lowest
  always_comb begin
    lookup_o = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (beg_vec[e]) begin
        lookup_o.beg_hit  = 1'b1;
        lookup_o.beg_free = !used_q[e];
        lookup_o.beg_slot = IDX_W'(e);
      end
      if (end_vec[e]) begin
        lookup_o.end_hit  = 1'b1;
        lookup_o.end_slot = IDX_W'(e);
      end
    end
  end

  assign used_o = used_q;

endmodule

/* hw/rtl/its_update.sv */
// Read-modify-write datapath: new entry value for begin, end or read.
// Depends on its_pkg for stat_t and act_e.
module its_update (
  input  its_pkg::act_e                 op_i,
  input  logic                          alloc_i,
  input  logic [its_pkg::TAG_BITS-1:0]  key_i,
  input  logic [its_pkg::TIME_BITS-1:0] ts_i,
  input  its_pkg::stat_t                old_i,
  output its_pkg::stat_t                new_o
);
  import its_pkg::*;

  stat_t               base;
  logic [TIME_BITS-1:0]  dur;
  logic [TOTAL_BITS:0]   sum;
  logic                  gt0, gt1, lt0, lt1;

  // allocation starts from a blank entry instead of the stale memory word
  always_comb begin
    base = old_i;
    if (alloc_i) begin
      base.tag   = key_i;
      base.count = '0;
      base.total = '0;
      base.max0  = '0;
      base.max1  = '0;
      base.min0  = '1;
      base.min1  = '1;
    end
  end

  assign dur = TIME_BITS'(ts_i - old_i.start);
  assign sum = {1'b0, old_i.total} + (TOTAL_BITS + 1)'(dur);
  // pairs stay ordered (max0 >= max1, min0 <= min1), so both compares run in parallel
  assign gt0 = dur > old_i.max0;
  assign gt1 = dur > old_i.max1;
  assign lt0 = dur < old_i.min0;
  assign lt1 = dur < old_i.min1;

  always_comb begin
    new_o = base;
    case (op_i)
      ACT_BEGIN: begin
        new_o.start = ts_i;
        if (base.count != '1) begin
          new_o.count = base.count + CNT_BITS'(1);
        end
      end
      ACT_END: begin
        new_o.total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
        new_o.max0  = gt0 ? dur : old_i.max0;
        new_o.max1  = gt0 ? old_i.max0 : (gt1 ? dur : old_i.max1);
        new_o.min0  = lt0 ? dur : old_i.min0;
        new_o.min1  = lt0 ? old_i.min0 : (lt1 ? dur : old_i.min1);
      end
      default: begin
        new_o = base;
      end
    endcase
  end

endmodule

/* hw/rtl/tagged_interval_stats_table.sv */
// Tagged interval statistics table, top level.
// Flow: tag compare and memory read when a beat is taken, then update,
// write-back and output register, which wait while the output is full and not
// ready. No new beat is taken before the last one's single read-modify-write.
// Reset: all entries free and the output empty; memory contents undefined.
module tagged_interval_stats_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: tag_key[31:0], timestamp[79:32], entry_index[85:80], zeros above
  input  logic [its_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: slot[5:0], slot_used[6], slot_key[38:7], call_count[70:39],
  // total_ticks[134:71], longest[182:135], second_longest[230:183],
  // shortest[278:231], second_shortest[326:279], zero[327]
  output logic [its_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                        m_axis_tuser
);
  import its_pkg::*;

  fsm_e st_q, st_d;

  logic [TAG_BITS-1:0]  in_key;
  logic [TIME_BITS-1:0] in_ts;
  logic [SLOT_W-1:0]    in_idx;
  act_e                 in_act;

  lookup_t            lookup;
  logic [ENTRIES-1:0] used;
  cam_wr_t            cam_wr;

  logic               accept, commit;
  logic [IDX_W-1:0]   rd_addr;
  logic               in_hit, in_alloc, idx_ok;

  act_e                 op_q;
  logic [TAG_BITS-1:0]  key_q;
  logic [TIME_BITS-1:0] ts_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [IDX_W-1:0]     slot_q;
  logic                 hit_q, alloc_q;

  stat_t rd_data, new_stat;
  logic  mem_wr;

  logic                      m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0]    m_data_q, m_data_d;
  logic [1:0]                m_user_q, m_user_d;

  assign in_key = s_axis_tdata[31:0];
  assign in_ts  = s_axis_tdata[79:32];
  assign in_idx = s_axis_tdata[85:80];
  assign in_act = act_e'(s_axis_tuser);

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FSM_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      FSM_IDLE: if (s_axis_tvalid) st_d = FSM_UPD;
      FSM_UPD:  if (!m_valid_q || m_axis_tready) st_d = FSM_IDLE;
      default:  st_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    unique case (st_q)
      FSM_IDLE: s_axis_tready = 1'b1;
      FSM_UPD:  commit = !m_valid_q || m_axis_tready;
      default:  ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------- lookup ----------------
  its_tag_cam u_cam (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (in_key),
    .wr_i     (cam_wr),
    .lookup_o (lookup),
    .used_o   (used)
  );

  assign idx_ok = (32'(in_idx) < ENTRIES) && used[IDX_W'(in_idx)];

  always_comb begin
    rd_addr  = '0;
    in_hit   = 1'b0;
    in_alloc = 1'b0;
    unique case (in_act)
      ACT_BEGIN: begin
        rd_addr  = lookup.beg_slot;
        in_hit   = lookup.beg_hit;
        in_alloc = lookup.beg_free;
      end
      ACT_END: begin
        rd_addr = lookup.end_slot;
        in_hit  = lookup.end_hit;
      end
      ACT_READ: begin
        rd_addr = IDX_W'(in_idx);
        in_hit  = idx_ok;
      end
      default: begin
        in_hit = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= ACT_BEGIN;
      hit_q   <= 1'b0;
      alloc_q <= 1'b0;
    end else if (accept) begin
      op_q    <= in_act;
      hit_q   <= in_hit;
      alloc_q <= in_alloc && in_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= in_key;
      ts_q   <= in_ts;
      idx_q  <= in_idx;
      slot_q <= rd_addr;
    end
  end

  // ---------------- memory and update ----------------
  assign mem_wr = commit && hit_q && (op_q == ACT_BEGIN || op_q == ACT_END);

  its_stat_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_wr),
    .wr_addr_i (slot_q),
    .wr_data_i (new_stat)
  );

  its_update u_upd (
    .op_i    (op_q),
    .alloc_i (alloc_q),
    .key_i   (key_q),
    .ts_i    (ts_q),
    .old_i   (rd_data),
    .new_o   (new_stat)
  );

  always_comb begin
    cam_wr           = '0;
    cam_wr.wr_en     = commit && alloc_q && op_q == ACT_BEGIN;
    cam_wr.slot      = slot_q;
    cam_wr.key       = key_q;
    cam_wr.clear_all = commit && op_q == ACT_CLEAR;
  end

  // ---------------- output register ----------------
  always_comb begin
    m_data_d = '0;
    m_user_d = STS_OK;
    if (op_q == ACT_CLEAR) begin
      m_user_d = STS_OK;
    end else if (!hit_q) begin
      unique case (op_q)
        ACT_BEGIN: m_user_d = STS_FULL;
        ACT_END:   m_user_d = STS_NOT_FOUND;
        default: begin
          m_user_d        = STS_UNUSED;
          m_data_d[5:0]   = idx_q;
        end
      endcase
    end else begin
      m_data_d[5:0]     = SLOT_W'(slot_q);
      m_data_d[6]       = 1'b1;
      m_data_d[38:7]    = new_stat.tag;
      m_data_d[70:39]   = new_stat.count;
      m_data_d[134:71]  = new_stat.total;
      m_data_d[182:135] = new_stat.max0;
      m_data_d[230:183] = new_stat.max1;
      m_data_d[278:231] = new_stat.min0;
      m_data_d[326:279] = new_stat.min1;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (commit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
